// ----- src/hrsp_pkg.sv -----
// Shared types, codes and character tables for the HTTP request stream parser.
`default_nettype none
package hrsp_pkg;

   localparam int MAX_HEADERS_DEF = 64;
   localparam int LENGTH_BITS_DEF = 32;
   localparam logic [6:0] HEADER_LIMIT_RESET = 7'd64;

   localparam logic [3:0] ROLE_METHOD  = 4'd0;
   localparam logic [3:0] ROLE_DELIM   = 4'd1;
   localparam logic [3:0] ROLE_URI     = 4'd2;
   localparam logic [3:0] ROLE_VERSION = 4'd3;
   localparam logic [3:0] ROLE_NAME    = 4'd4;
   localparam logic [3:0] ROLE_LEAD    = 4'd5;
   localparam logic [3:0] ROLE_VALUE   = 4'd6;
   localparam logic [3:0] ROLE_CSIZE   = 4'd7;
   localparam logic [3:0] ROLE_BODY    = 4'd8;
   localparam logic [3:0] ROLE_IGNORED = 4'd9;

   localparam logic [2:0] ST_BUSY       = 3'd0;
   localparam logic [2:0] ST_COMPLETE   = 3'd1;
   localparam logic [2:0] ST_BAD_METHOD = 3'd2;
   localparam logic [2:0] ST_VER_BAD    = 3'd3;
   localparam logic [2:0] ST_VER_UNK    = 3'd4;
   localparam logic [2:0] ST_TOO_MANY   = 3'd5;
   localparam logic [2:0] ST_CHUNK_BAD  = 3'd6;

   localparam logic [3:0] METH_NONE    = 4'd0;
   localparam logic [3:0] METH_GET     = 4'd1;
   localparam logic [3:0] METH_POST    = 4'd2;
   localparam logic [3:0] METH_PUT     = 4'd3;
   localparam logic [3:0] METH_PATCH   = 4'd4;
   localparam logic [3:0] METH_HEAD    = 4'd5;
   localparam logic [3:0] METH_DELETE  = 4'd6;
   localparam logic [3:0] METH_CONNECT = 4'd7;
   localparam logic [3:0] METH_OPTIONS = 4'd8;
   localparam logic [3:0] METH_TRACE   = 4'd9;

   localparam logic [1:0] BODY_EOS     = 2'd0;
   localparam logic [1:0] BODY_LENGTH  = 2'd1;
   localparam logic [1:0] BODY_CHUNKED = 2'd2;

   localparam logic [1:0] VER_NONE = 2'd0;
   localparam logic [1:0] VER_1_0  = 2'd1;
   localparam logic [1:0] VER_1_1  = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3a;

   localparam logic [4:0] NAME_DEAD = 5'd31;
   localparam logic [4:0] TE_LEN    = 5'd17;
   localparam logic [4:0] CL_LEN    = 5'd14;

   localparam logic [135:0] TE_TEXT    = "transfer-encoding";
   localparam logic [111:0] CL_TEXT    = "content-length";
   localparam logic [55:0]  CHUNK_TEXT = "chunked";
   localparam logic [55:0]  VER_TEXT   = "HTTP/1.";

   // One byte with its character class worked out ahead of the parser.
   typedef struct packed {
      logic [7:0] data;
      logic       new_request;
      logic [7:0] low;
      logic       ws;
      logic       dec;
      logic       hex;
      logic [3:0] nib;
   } class_type;

   function automatic class_type classify(logic [7:0] b);
      class_type c;
      c.data = b;
      c.new_request = 1'b0;
      c.low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      c.ws = (b == CH_SP) || (b == CH_HT);
      c.dec = (b >= "0" && b <= "9");
      c.hex = c.dec || (c.low >= "a" && c.low <= "f");
      c.nib = c.dec ? b[3:0] : 4'(c.low - 8'h57);
      return c;
   endfunction

   function automatic logic [2:0] meth_len(logic [3:0] m);
      logic [2:0] n;
      case (m)
         METH_GET, METH_PUT:                    n = 3'd3;
         METH_POST, METH_HEAD:                  n = 3'd4;
         METH_PATCH, METH_TRACE:                n = 3'd5;
         METH_DELETE:                           n = 3'd6;
         METH_CONNECT, METH_OPTIONS:            n = 3'd7;
         default:                               n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] meth_char(logic [3:0] m, logic [2:0] pos);
      logic [55:0] t;
      case (m)
         METH_GET:     t = "GET    ";
         METH_POST:    t = "POST   ";
         METH_PUT:     t = "PUT    ";
         METH_PATCH:   t = "PATCH  ";
         METH_HEAD:    t = "HEAD   ";
         METH_DELETE:  t = "DELETE ";
         METH_CONNECT: t = "CONNECT";
         METH_OPTIONS: t = "OPTIONS";
         METH_TRACE:   t = "TRACE  ";
         default:      t = "       ";
      endcase
      return (pos < 3'd7) ? t[55 - 8 * pos -: 8] : 8'd0;
   endfunction

   function automatic logic [7:0] name_char(logic which, logic [4:0] pos);
      logic [7:0] ch;
      ch = 8'd0;
      if (which) begin
         if (pos < CL_LEN) ch = CL_TEXT[111 - 8 * pos -: 8];
      end else begin
         if (pos < TE_LEN) ch = TE_TEXT[135 - 8 * pos -: 8];
      end
      return ch;
   endfunction

   function automatic logic [7:0] chunk_char(logic [3:0] pos);
      return (pos < 4'd7) ? CHUNK_TEXT[55 - 8 * pos -: 8] : 8'd0;
   endfunction

   function automatic logic [7:0] ver_char(logic [2:0] pos);
      return (pos < 3'd7) ? VER_TEXT[55 - 8 * pos -: 8] : 8'd0;
   endfunction

endpackage
`default_nettype wire

// ----- src/hrsp_req_if.sv -----
// Request byte channel: valid, ready, one raw byte and the new_request flag.
`default_nettype none
interface hrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       new_request;

   modport source (output valid, byte_in, new_request, input ready);
   modport sink (input valid, byte_in, new_request, output ready);
endinterface
`default_nettype wire

// ----- src/hrsp_rsp_if.sv -----
// Result channel: valid, ready and the tag of one parsed byte.
`default_nettype none
interface hrsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  role;
   logic [2:0]  status;
   logic [3:0]  method_code;
   logic [1:0]  version_code;
   logic [6:0]  header_index;
   logic        field_end;
   logic [15:0] value_length;
   logic [1:0]  body_kind;
   logic [31:0] length_value;
   logic [31:0] byte_offset;

   modport source (output valid, role, status, method_code, version_code, header_index,
                   field_end, value_length, body_kind, length_value, byte_offset,
                   input ready);
   modport sink (input valid, role, status, method_code, version_code, header_index,
                 field_end, value_length, body_kind, length_value, byte_offset,
                 output ready);
endinterface
`default_nettype wire

// ----- src/http_request_stream_parser_unit.sv -----
// Top level of the HTTP request stream parser.
// Usage:
//   req_chan carries one request byte per transaction with new_request, which
//   restarts the parse on that byte. rsp_chan returns one tagged transaction
//   per byte, in order: role, status, method, version, header index, field
//   end, trimmed value length, body framing, length and byte offset.
//   csr_we/csr_wdata write the header limit (reset 64); write it only while
//   no transaction is in flight.
// Timing:
//   A byte passes a classify register, a two-entry queue and the parse
//   register before its result is on rsp_chan.
//   Throughput is one byte per cycle while rsp_chan does not stall, set
//   by the parse step of the back state machine.
// Reset clears all parse state and empties the pipeline; the header limit
// returns to 64. When rsp_chan stalls, the result register holds, the queue
// fills and req_chan ready then drops; nothing is lost.
`default_nettype none
module http_request_stream_parser_unit
   import hrsp_pkg::*;
#(
   parameter int MAX_HEADERS = MAX_HEADERS_DEF,
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   hrsp_req_if.sink        req_chan,
   hrsp_rsp_if.source      rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata
);
   logic [6:0] header_limit_ff, header_limit_in;
   class_type  f_data, q_data;
   logic       f_valid, f_ready, q_valid, q_ready;

   assign header_limit_in = csr_we ? csr_wdata : header_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= HEADER_LIMIT_RESET;
      end else begin
         header_limit_ff <= header_limit_in;
      end
   end

   hrsp_front u_front (
      .clock(clock), .reset(reset), .req(req_chan),
      .out_data(f_data), .out_valid(f_valid), .out_ready(f_ready)
   );

   hrsp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_data(f_data), .in_valid(f_valid), .in_ready(f_ready),
      .out_data(q_data), .out_valid(q_valid), .out_ready(q_ready)
   );

   hrsp_back #(.MAX_HEADERS(MAX_HEADERS), .LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock(clock), .reset(reset), .header_limit(header_limit_ff),
      .in_data(q_data), .in_valid(q_valid), .in_ready(q_ready), .rsp(rsp_chan)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
   a_error_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status >= ST_BAD_METHOD |-> rsp_chan.role == ROLE_IGNORED)
      else $error("error status on a byte that is not ignored");
   a_field_end_role: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.field_end |->
         rsp_chan.role == ROLE_METHOD || rsp_chan.role == ROLE_DELIM
         || rsp_chan.role == ROLE_BODY)
      else $error("field end on an unexpected role");
   a_vlen_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.value_length != 16'd0 |-> rsp_chan.field_end)
      else $error("value length outside a line end");
`endif
endmodule
`default_nettype wire

// ----- src/hrsp_front.sv -----
// Front stage: accepts request bytes and registers their character class.
`default_nettype none
module hrsp_front
   import hrsp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   hrsp_req_if.sink   req,
   output class_type  out_data,
   output logic       out_valid,
   input  wire logic  out_ready
);
   logic      valid_ff, valid_in;
   class_type data_ff, data_in;

   assign req.ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (req.ready) begin
         valid_in = req.valid;
         data_in = classify(req.byte_in);
         data_in.new_request = req.new_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule
`default_nettype wire

// ----- src/hrsp_queue.sv -----
// Two-entry queue between the classifier and the parser.
`default_nettype none
module hrsp_queue
   import hrsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire class_type  in_data,
   input  wire logic       in_valid,
   output logic            in_ready,
   output class_type       out_data,
   output logic            out_valid,
   input  wire logic       out_ready
);
   class_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = mem[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

// ----- src/hrsp_back.sv -----
// Back stage: the request parse state machine and the result register.
`default_nettype none
module hrsp_back
   import hrsp_pkg::*;
#(
   parameter int MAX_HEADERS = MAX_HEADERS_DEF,
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] header_limit,
   input  wire class_type  in_data,
   input  wire logic       in_valid,
   output logic            in_ready,
   hrsp_rsp_if.source      rsp
);
   localparam int HW = $clog2(MAX_HEADERS + 1);
   localparam int LB = LENGTH_BITS;
   localparam int CW = 10;

   typedef enum logic [4:0] {
      PH_MFIRST, PH_MLIT, PH_URI, PH_VER, PH_VCR, PH_VLF, PH_LINE, PH_BLANK,
      PH_NAME, PH_LEAD, PH_VALUE, PH_CLBODY, PH_CSIZE, PH_CDATA, PH_CDCR,
      PH_CDLF, PH_CLCR, PH_CLLF, PH_EOS, PH_DONE, PH_ERR
   } phase_type;

   typedef struct packed {
      logic [15:0]   vcnt;
      logic [15:0]   tcnt;
      logic [3:0]    vm;
      logic [LB-1:0] acc;
   } val_type;

   typedef struct packed {
      phase_type     phase;
      logic [2:0]    lit;
      logic [3:0]    meth;
      logic [1:0]    ver;
      logic [HW-1:0] hcnt;
      logic [5:0]    nm;
      logic [1:0]    bmode;
      logic          pcr;
      logic [LB-1:0] bleft;
      logic [31:0]   pos;
      val_type       v;
   } pstate_type;

   localparam pstate_type CLEARED = '{
      phase: PH_MFIRST, lit: 3'd0, meth: METH_NONE, ver: VER_NONE, hcnt: '0, nm: 6'd0,
      bmode: BODY_EOS, pcr: 1'b0, bleft: '0, pos: 32'd0, v: '0};

   pstate_type  st_ff, st_in;
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  role_ff, role_in, meth_ff, meth_in;
   logic [2:0]  status_ff, status_in;
   logic [1:0]  ver_ff, ver_in, bkind_ff, bkind_in;
   logic [6:0]  idx_ff, idx_in;
   logic        fe_ff, fe_in;
   logic [15:0] vlen_ff, vlen_in;
   logic [31:0] len_ff, len_in, offs_ff, offs_in;
   logic        take;

   function automatic logic name_is(logic [5:0] nm, logic which);
      return (nm[4:0] != NAME_DEAD) && (nm[5] == which)
             && (nm[4:0] == (which ? CL_LEN : TE_LEN));
   endfunction

   function automatic logic [5:0] name_step(logic [5:0] nm, logic [7:0] c);
      logic [5:0] r;
      r = nm;
      if (nm[4:0] == 5'd0) begin
         r = (c == "t") ? 6'd1 : (c == "c") ? {1'b1, 5'd1} : {1'b0, NAME_DEAD};
      end else if (nm[4:0] != NAME_DEAD) begin
         if (nm[4:0] < (nm[5] ? CL_LEN : TE_LEN) && c == name_char(nm[5], nm[4:0])) begin
            r = {nm[5], nm[4:0] + 5'd1};
         end else begin
            r = {nm[5], NAME_DEAD};
         end
      end
      return r;
   endfunction

   // Shift-add accumulate; the top nibble of the wide sum flags overflow.
   function automatic val_type acc_digit(val_type v, logic [3:0] d, logic hex);
      logic [LB+3:0] w;
      val_type r;
      r = v;
      if (!v.vm[1]) begin
         w = hex ? {v.acc, 4'b0} : ({1'b0, v.acc, 3'b0} + {3'b0, v.acc, 1'b0});
         w = w + (LB + 4)'(d);
         if (w[LB+3:LB] != 4'd0) begin
            r.vm = v.vm | 4'd6;
         end else begin
            r.acc = w[LB-1:0];
            r.vm = v.vm | 4'd1;
         end
      end
      return r;
   endfunction

   function automatic val_type value_byte(val_type v, class_type c, logic [5:0] nm,
                                          logic [1:0] bmode);
      val_type r;
      r = v;
      if (r.vcnt != 16'hffff) r.vcnt = r.vcnt + 16'd1;
      if (!c.ws) r.tcnt = r.vcnt;
      if (bmode == BODY_EOS) begin
         if (name_is(nm, 1'b0)) begin
            if (r.vm < 4'd7) begin
               r.vm = (c.low == chunk_char(r.vm)) ? r.vm + 4'd1 : 4'd15;
            end else if (r.vm == 4'd7 && !c.ws) begin
               r.vm = 4'd15;
            end
         end else if (name_is(nm, 1'b1)) begin
            if (c.dec) r = acc_digit(r, c.nib, 1'b0);
            else r.vm = r.vm | 4'd2;
         end
      end
      return r;
   endfunction

   function automatic val_type size_byte(val_type v, class_type c);
      val_type r;
      r = v;
      if (c.hex) r = acc_digit(r, c.nib, 1'b1);
      else r.vm = r.vm | 4'd2;
      return r;
   endfunction

   always_comb begin
      pstate_type s, n;
      class_type  c, cr;
      logic [3:0] m;
      logic [2:0] len;
      logic [CW-1:0] limit;
      s = in_data.new_request ? CLEARED : st_ff;
      s.pos = in_data.new_request ? 32'd0 : st_ff.pos;
      n = s;
      c = in_data;
      cr = classify(CH_CR);
      m = METH_NONE;
      len = meth_len(s.meth);
      limit = (CW'(header_limit) > CW'(MAX_HEADERS)) ? CW'(MAX_HEADERS)
                                                     : CW'(header_limit);
      role_in = ROLE_IGNORED;
      fe_in = 1'b0;
      vlen_in = 16'd0;
      idx_in = (s.phase >= PH_LINE && s.phase <= PH_VALUE) ? 7'(s.hcnt) : 7'd0;
      case (s.phase)
         PH_MFIRST: begin
            m = (c.data == "G") ? METH_GET : (c.data == "H") ? METH_HEAD :
                (c.data == "D") ? METH_DELETE : (c.data == "C") ? METH_CONNECT :
                (c.data == "O") ? METH_OPTIONS : (c.data == "T") ? METH_TRACE :
                (c.data == "P") ? METH_NONE : 4'd15;
            if (m == 4'd15) begin
               n.phase = PH_ERR;
               n.lit = ST_BAD_METHOD;
            end else begin
               n.meth = m;
               n.lit = 3'd1;
               n.phase = PH_MLIT;
               role_in = ROLE_METHOD;
            end
         end
         PH_MLIT: begin
            if (s.meth == METH_NONE) begin
               m = (c.data == "O") ? METH_POST : (c.data == "U") ? METH_PUT :
                   (c.data == "A") ? METH_PATCH : METH_NONE;
               if (m == METH_NONE) begin
                  n.phase = PH_ERR;
                  n.lit = ST_BAD_METHOD;
               end else begin
                  n.meth = m;
                  n.lit = 3'd2;
                  role_in = ROLE_METHOD;
               end
            end else if (s.lit < len) begin
               if (c.data != meth_char(s.meth, s.lit)) begin
                  n.phase = PH_ERR;
                  n.lit = ST_BAD_METHOD;
               end else begin
                  n.lit = s.lit + 3'd1;
                  role_in = ROLE_METHOD;
                  fe_in = (s.lit + 3'd1 == len);
               end
            end else if (c.data == CH_SP) begin
               role_in = ROLE_DELIM;
               n.phase = PH_URI;
            end else begin
               n.phase = PH_ERR;
               n.lit = ST_BAD_METHOD;
            end
         end
         PH_URI: begin
            if (c.data == CH_SP) begin
               role_in = ROLE_DELIM;
               fe_in = 1'b1;
               n.phase = PH_VER;
               n.lit = 3'd0;
            end else begin
               role_in = ROLE_URI;
            end
         end
         PH_VER: begin
            if (s.lit < 3'd7) begin
               if (c.data != ver_char(s.lit)) begin
                  n.phase = PH_ERR;
                  n.lit = (s.lit == 3'd5) ? ST_VER_UNK : ST_VER_BAD;
               end else begin
                  n.lit = s.lit + 3'd1;
                  role_in = ROLE_VERSION;
               end
            end else if (c.data == "0" || c.data == "1") begin
               n.ver = (c.data == "0") ? VER_1_0 : VER_1_1;
               role_in = ROLE_VERSION;
               n.phase = PH_VCR;
            end else begin
               n.phase = PH_ERR;
               n.lit = ST_VER_UNK;
            end
         end
         PH_VCR: begin
            if (c.data == CH_CR) begin
               role_in = ROLE_DELIM;
               n.phase = PH_VLF;
            end else begin
               n.phase = PH_ERR;
               n.lit = ST_VER_BAD;
            end
         end
         PH_VLF: begin
            if (c.data == CH_LF) begin
               role_in = ROLE_DELIM;
               n.phase = PH_LINE;
               n.nm = 6'd0;
            end else begin
               n.phase = PH_ERR;
               n.lit = ST_VER_BAD;
            end
         end
         PH_LINE, PH_BLANK, PH_NAME: begin
            if (s.phase == PH_LINE && c.data == CH_CR) begin
               role_in = ROLE_DELIM;
               n.phase = PH_BLANK;
            end else if (s.phase == PH_BLANK && c.data == CH_LF) begin
               // End of the header block picks the body framing.
               role_in = ROLE_DELIM;
               if (s.bmode == BODY_LENGTH) begin
                  n.bleft = s.v.acc;
                  n.phase = (s.v.acc == '0) ? PH_DONE : PH_CLBODY;
               end else if (s.bmode == BODY_CHUNKED) begin
                  n.phase = PH_CSIZE;
                  n.v.acc = '0;
                  n.v.vm = 4'd0;
                  n.pcr = 1'b0;
               end else begin
                  n.phase = PH_EOS;
               end
            end else begin
               // A lone CR after a line end counts as the first name byte.
               if (s.phase == PH_BLANK) n.nm = name_step(n.nm, cr.low);
               n.phase = PH_NAME;
               if (c.data == CH_COLON) begin
                  role_in = ROLE_DELIM;
                  fe_in = 1'b1;
                  n.phase = PH_LEAD;
                  n.v.vcnt = 16'd0;
                  n.v.tcnt = 16'd0;
                  n.v.vm = 4'd0;
                  n.pcr = 1'b0;
               end else begin
                  role_in = ROLE_NAME;
                  n.nm = name_step(n.nm, c.low);
               end
            end
         end
         PH_LEAD, PH_VALUE: begin
            if (s.phase == PH_LEAD && c.ws) begin
               role_in = ROLE_LEAD;
            end else if (s.phase == PH_VALUE && s.pcr && c.data == CH_LF) begin
               if (CW'(s.hcnt) >= limit) begin
                  n.phase = PH_ERR;
                  n.lit = ST_TOO_MANY;
               end else begin
                  role_in = ROLE_DELIM;
                  fe_in = 1'b1;
                  vlen_in = s.v.tcnt;
                  if (s.bmode == BODY_EOS) begin
                     if (name_is(s.nm, 1'b0) && s.v.vm == 4'd7) begin
                        n.bmode = BODY_CHUNKED;
                     end else if (name_is(s.nm, 1'b1) && s.v.tcnt != 16'd0) begin
                        n.bmode = BODY_LENGTH;
                        if (s.v.vm[2]) n.v.acc = '0;
                     end else begin
                        n.v.acc = '0;
                     end
                  end
                  n.hcnt = s.hcnt + HW'(1);
                  n.phase = PH_LINE;
                  n.pcr = 1'b0;
                  n.nm = 6'd0;
                  n.v.vm = 4'd0;
                  n.v.vcnt = 16'd0;
                  n.v.tcnt = 16'd0;
               end
            end else begin
               n.phase = PH_VALUE;
               if (s.phase == PH_VALUE && s.pcr) begin
                  n.pcr = 1'b0;
                  n.v = value_byte(n.v, cr, s.nm, s.bmode);
               end
               if (c.data == CH_CR) begin
                  n.pcr = 1'b1;
                  role_in = ROLE_DELIM;
               end else begin
                  n.v = value_byte(n.v, c, s.nm, s.bmode);
                  role_in = ROLE_VALUE;
               end
            end
         end
         PH_CLBODY, PH_CDATA: begin
            role_in = ROLE_BODY;
            if (s.bleft != '0) n.bleft = s.bleft - LB'(1);
            if (n.bleft == '0) begin
               if (s.phase == PH_CDATA) begin
                  fe_in = 1'b1;
                  n.phase = PH_CDCR;
               end else begin
                  n.phase = PH_DONE;
               end
            end
         end
         PH_CSIZE: begin
            if (s.pcr && c.data == CH_LF) begin
               if (!s.v.vm[0] || s.v.vm[2]) begin
                  n.phase = PH_ERR;
                  n.lit = ST_CHUNK_BAD;
               end else begin
                  role_in = ROLE_DELIM;
                  n.pcr = 1'b0;
                  if (s.v.acc == '0) begin
                     n.phase = PH_CLCR;
                  end else begin
                     n.bleft = s.v.acc;
                     n.phase = PH_CDATA;
                  end
               end
            end else begin
               if (s.pcr) begin
                  n.pcr = 1'b0;
                  n.v = size_byte(n.v, cr);
               end
               if (c.data == CH_CR) begin
                  n.pcr = 1'b1;
                  role_in = ROLE_DELIM;
               end else begin
                  n.v = size_byte(n.v, c);
                  role_in = ROLE_CSIZE;
               end
            end
         end
         PH_CDCR, PH_CLCR: begin
            if (c.data == CH_CR) begin
               role_in = ROLE_DELIM;
               n.phase = (s.phase == PH_CDCR) ? PH_CDLF : PH_CLLF;
            end else begin
               n.phase = PH_ERR;
               n.lit = ST_CHUNK_BAD;
            end
         end
         PH_CDLF, PH_CLLF: begin
            if (c.data == CH_LF) begin
               role_in = ROLE_DELIM;
               if (s.phase == PH_CDLF) begin
                  n.phase = PH_CSIZE;
                  n.v.acc = '0;
                  n.v.vm = 4'd0;
                  n.pcr = 1'b0;
               end else begin
                  n.phase = PH_DONE;
               end
            end else begin
               n.phase = PH_ERR;
               n.lit = ST_CHUNK_BAD;
            end
         end
         PH_EOS: begin
            role_in = ROLE_BODY;
         end
         default: begin
         end
      endcase
      if (n.phase == PH_ERR) begin
         role_in = ROLE_IGNORED;
         fe_in = 1'b0;
         vlen_in = 16'd0;
      end
      if (n.phase == PH_DONE || n.phase == PH_EOS) status_in = ST_COMPLETE;
      else if (n.phase == PH_ERR) status_in = n.lit;
      else status_in = ST_BUSY;
      meth_in = (n.phase == PH_MFIRST || n.phase == PH_MLIT
                 || (n.phase == PH_ERR && n.lit == ST_BAD_METHOD)) ? METH_NONE : n.meth;
      ver_in = n.ver;
      bkind_in = n.bmode;
      len_in = 32'(n.v.acc);
      offs_in = s.pos;
      if (s.pos != 32'hffff_ffff) n.pos = s.pos + 32'd1;
      st_in = n;
   end

   assign in_ready = !out_valid_ff || rsp.ready;
   assign take = in_valid && in_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) out_valid_in = 1'b1;
      else if (rsp.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CLEARED;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) st_ff <= st_in;
      end
      if (take) begin
         role_ff <= role_in;
         status_ff <= status_in;
         meth_ff <= meth_in;
         ver_ff <= ver_in;
         idx_ff <= idx_in;
         fe_ff <= fe_in;
         vlen_ff <= vlen_in;
         bkind_ff <= bkind_in;
         len_ff <= len_in;
         offs_ff <= offs_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.role = role_ff;
   assign rsp.status = status_ff;
   assign rsp.method_code = meth_ff;
   assign rsp.version_code = ver_ff;
   assign rsp.header_index = idx_ff;
   assign rsp.field_end = fe_ff;
   assign rsp.value_length = vlen_ff;
   assign rsp.body_kind = bkind_ff;
   assign rsp.length_value = len_ff;
   assign rsp.byte_offset = offs_ff;
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the HTTP request stream parser: directed table, then random requests.
`default_nettype none
module testbench;
   import hrsp_pkg::*;

   typedef struct packed {
      logic [3:0]  role;
      logic [2:0]  status;
      logic [3:0]  method_code;
      logic [1:0]  version_code;
      logic [6:0]  header_index;
      logic        field_end;
      logic [15:0] value_length;
      logic [1:0]  body_kind;
      logic [31:0] length_value;
      logic [31:0] byte_offset;
   } tag_t;

   typedef enum logic [4:0] {
      P_MFIRST, P_MLIT, P_URI, P_VER, P_VCR, P_VLF, P_LINE, P_BLANK, P_NAME, P_LEAD,
      P_VALUE, P_CLBODY, P_CSIZE, P_CDATA, P_CDCR, P_CDLF, P_CLCR, P_CLLF, P_EOS,
      P_DONE, P_ERR
   } parse_phase_t;

   // One directed row: byte, restart flag, whether a result is typed in, and that result.
   typedef struct {
      logic [7:0] data;
      logic       restart;
      logic       typed;
      logic [3:0] role;
      logic [2:0] status;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [6:0] csr_wdata = 7'd0;

   hrsp_req_if req_chan ();
   hrsp_rsp_if rsp_chan ();

   http_request_stream_parser_unit u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic [6:0]   lim;
   parse_phase_t ph;
   logic [2:0]   lpos;
   logic [3:0]   meth;
   logic [1:0]   ver;
   logic [6:0]   hcount;
   logic [5:0]   nmatch;
   logic [3:0]   vmatch;
   logic [1:0]   bmode;
   logic [31:0]  acc;
   logic [31:0]  left;
   logic [15:0]  vcount, tcount;
   logic [31:0]  offset;
   logic         cr_seen;
   logic [3:0]   o_role;
   logic         o_fe;
   logic [15:0]  o_vlen;

   tag_t tag_queue[$];
   logic typed_queue[$];
   int   errors = 0;

   function automatic logic [7:0] lower_ch(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic is_ws(logic [7:0] c);
      return c == CH_SP || c == CH_HT;
   endfunction

   function automatic logic [7:0] char_at(string s, int p);
      return (p < s.len()) ? s[p] : 8'd0;
   endfunction

   function automatic logic [7:0] te_at(int p);
      string s;
      s = "transfer-encoding";
      return s[p];
   endfunction

   function automatic logic [7:0] cl_at(int p);
      string s;
      s = "content-length";
      return s[p];
   endfunction

   function automatic logic [7:0] method_at(logic [3:0] m, int p);
      string s[10];
      s = '{"", "GET", "POST", "PUT", "PATCH", "HEAD", "DELETE", "CONNECT", "OPTIONS", "TRACE"};
      return (p < s[m].len()) ? s[m][p] : 8'd0;
   endfunction

   function automatic int method_len(logic [3:0] m);
      int n[10];
      n = '{0, 3, 4, 3, 5, 4, 6, 7, 7, 5};
      return n[m];
   endfunction

   function automatic void fail_with(logic [2:0] code);
      ph = P_ERR;
      lpos = code;
      o_role = ROLE_IGNORED;
      o_fe = 1'b0;
      o_vlen = 16'd0;
   endfunction

   function automatic void track_name(logic [7:0] b);
      logic [4:0] p;
      logic       w;
      logic [7:0] c;
      p = nmatch[4:0];
      w = nmatch[5];
      c = lower_ch(b);
      if (p == NAME_DEAD) return;
      if (p == 0) begin
         nmatch = (c == "t") ? 6'd1 : (c == "c") ? 6'd33 : 6'd31;
      end else if (p < (w ? CL_LEN : TE_LEN) && c == (w ? cl_at(p) : te_at(p))) begin
         nmatch = {w, p + 5'd1};
      end else begin
         nmatch = {w, NAME_DEAD};
      end
   endfunction

   function automatic logic name_hit(logic w);
      return nmatch[4:0] != NAME_DEAD && nmatch[5] == w && nmatch[4:0] == (w ? CL_LEN : TE_LEN);
   endfunction

   function automatic void add_digit(logic [31:0] d, logic [31:0] base);
      if (vmatch[1]) return;
      if (acc > (32'hFFFF_FFFF - d) / base) begin
         vmatch = vmatch | 4'd6;
      end else begin
         acc = acc * base + d;
         vmatch = vmatch | 4'd1;
      end
   endfunction

   function automatic void value_char(logic [7:0] b);
      if (vcount != 16'hFFFF) vcount++;
      if (!is_ws(b)) tcount = vcount;
      if (bmode != BODY_EOS) return;
      if (name_hit(1'b0)) begin
         if (vmatch < 7) begin
            vmatch = (lower_ch(b) == char_at("chunked", int'(vmatch))) ? vmatch + 4'd1 : 4'd15;
         end else if (vmatch == 7 && !is_ws(b)) begin
            vmatch = 4'd15;
         end
      end else if (name_hit(1'b1)) begin
         if (b >= "0" && b <= "9") add_digit(b - "0", 10);
         else vmatch = vmatch | 4'd2;
      end
   endfunction

   function automatic void size_char(logic [7:0] b);
      logic [7:0] c;
      c = lower_ch(b);
      if (c >= "0" && c <= "9") add_digit(c - "0", 16);
      else if (c >= "a" && c <= "f") add_digit(c - "a" + 10, 16);
      else vmatch = vmatch | 4'd2;
   endfunction

   function automatic void name_char_step(logic [7:0] b);
      if (b == CH_COLON) begin
         o_role = ROLE_DELIM;
         o_fe = 1'b1;
         ph = P_LEAD;
         vcount = 0;
         tcount = 0;
         vmatch = 0;
         cr_seen = 0;
      end else begin
         o_role = ROLE_NAME;
         track_name(b);
      end
   endfunction

   function automatic void clear_parse();
      ph = P_MFIRST; lpos = 0; meth = 0; ver = 0; hcount = 0; nmatch = 0; vmatch = 0;
      bmode = BODY_EOS; cr_seen = 0; acc = 0; left = 0; vcount = 0; tcount = 0; offset = 0;
   endfunction

   function automatic tag_t parse_byte(logic [7:0] b, logic restart);
      tag_t t;
      logic [3:0] m;
      logic [6:0] idx;
      logic [6:0] eff;
      int p;
      if (restart) clear_parse();
      idx = (ph >= P_LINE && ph <= P_VALUE) ? hcount : 7'd0;
      o_role = ROLE_IGNORED; o_fe = 0; o_vlen = 0;
      case (ph)
         P_MFIRST: begin
            m = (b == "G") ? METH_GET : (b == "H") ? METH_HEAD : (b == "D") ? METH_DELETE :
                (b == "C") ? METH_CONNECT : (b == "O") ? METH_OPTIONS : (b == "T") ? METH_TRACE :
                (b == "P") ? METH_NONE : 4'd10;
            if (m == 4'd10) fail_with(ST_BAD_METHOD);
            else begin
               meth = m; lpos = 1; ph = P_MLIT; o_role = ROLE_METHOD;
            end
         end
         P_MLIT: begin
            if (meth == METH_NONE) begin
               m = (b == "O") ? METH_POST : (b == "U") ? METH_PUT : (b == "A") ? METH_PATCH : 4'd0;
               if (m == 0) fail_with(ST_BAD_METHOD);
               else begin
                  meth = m; lpos = 2; o_role = ROLE_METHOD;
               end
            end else begin
               p = lpos;
               if (p < method_len(meth)) begin
                  if (b != method_at(meth, p)) fail_with(ST_BAD_METHOD);
                  else begin
                     lpos = p + 1; o_role = ROLE_METHOD; o_fe = (p + 1 == method_len(meth));
                  end
               end else if (b == CH_SP) begin
                  o_role = ROLE_DELIM; ph = P_URI;
               end else fail_with(ST_BAD_METHOD);
            end
         end
         P_URI: begin
            if (b == CH_SP) begin
               o_role = ROLE_DELIM; o_fe = 1; ph = P_VER; lpos = 0;
            end else o_role = ROLE_URI;
         end
         P_VER: begin
            p = lpos;
            if (p < 7) begin
               if (b != char_at("HTTP/1.", p)) begin
                  fail_with(p == 5 ? ST_VER_UNK : ST_VER_BAD);
               end else begin
                  lpos = p + 1; o_role = ROLE_VERSION;
               end
            end else if (b == "0" || b == "1") begin
               ver = (b == "0") ? VER_1_0 : VER_1_1; o_role = ROLE_VERSION; ph = P_VCR;
            end else fail_with(ST_VER_UNK);
         end
         P_VCR: begin
            if (b == CH_CR) begin
               o_role = ROLE_DELIM; ph = P_VLF;
            end else fail_with(ST_VER_BAD);
         end
         P_VLF: begin
            if (b == CH_LF) begin
               o_role = ROLE_DELIM; ph = P_LINE; nmatch = 0;
            end else fail_with(ST_VER_BAD);
         end
         P_LINE: begin
            if (b == CH_CR) begin
               o_role = ROLE_DELIM; ph = P_BLANK;
            end else begin
               ph = P_NAME; name_char_step(b);
            end
         end
         P_BLANK: begin
            if (b == CH_LF) begin
               o_role = ROLE_DELIM;
               if (bmode == BODY_LENGTH) begin
                  left = acc; ph = (left == 0) ? P_DONE : P_CLBODY;
               end else if (bmode == BODY_CHUNKED) begin
                  ph = P_CSIZE; acc = 0; vmatch = 0; cr_seen = 0;
               end else ph = P_EOS;
            end else begin
               track_name(CH_CR); ph = P_NAME; name_char_step(b);
            end
         end
         P_NAME: name_char_step(b);
         P_LEAD, P_VALUE: begin
            if (ph == P_LEAD && is_ws(b)) o_role = ROLE_LEAD;
            else if (ph == P_VALUE && cr_seen && b == CH_LF) begin
               eff = (lim > 64) ? 7'd64 : lim;
               if (hcount >= eff) fail_with(ST_TOO_MANY);
               else begin
                  o_role = ROLE_DELIM; o_fe = 1; o_vlen = tcount;
                  if (bmode == BODY_EOS) begin
                     if (name_hit(1'b0) && vmatch == 7) bmode = BODY_CHUNKED;
                     else if (name_hit(1'b1) && tcount > 0) begin
                        bmode = BODY_LENGTH;
                        if (vmatch[2]) acc = 0;
                     end else acc = 0;
                  end
                  hcount++;
                  ph = P_LINE; cr_seen = 0; nmatch = 0; vmatch = 0; vcount = 0; tcount = 0;
               end
            end else begin
               if (ph == P_VALUE && cr_seen) begin
                  cr_seen = 0; value_char(CH_CR);
               end
               ph = P_VALUE;
               if (b == CH_CR) begin
                  cr_seen = 1; o_role = ROLE_DELIM;
               end else begin
                  value_char(b); o_role = ROLE_VALUE;
               end
            end
         end
         P_CLBODY: begin
            o_role = ROLE_BODY;
            if (left > 0) left--;
            if (left == 0) ph = P_DONE;
         end
         P_CSIZE: begin
            if (cr_seen && b == CH_LF) begin
               if (!vmatch[0] || vmatch[2]) fail_with(ST_CHUNK_BAD);
               else begin
                  o_role = ROLE_DELIM; cr_seen = 0;
                  if (acc == 0) ph = P_CLCR;
                  else begin
                     left = acc; ph = P_CDATA;
                  end
               end
            end else begin
               if (cr_seen) begin
                  cr_seen = 0; size_char(CH_CR);
               end
               if (b == CH_CR) begin
                  cr_seen = 1; o_role = ROLE_DELIM;
               end else begin
                  size_char(b); o_role = ROLE_CSIZE;
               end
            end
         end
         P_CDATA: begin
            o_role = ROLE_BODY;
            if (left > 0) left--;
            if (left == 0) begin
               o_fe = 1; ph = P_CDCR;
            end
         end
         P_CDCR, P_CLCR: begin
            if (b == CH_CR) begin
               o_role = ROLE_DELIM; ph = parse_phase_t'(ph + 1);
            end else fail_with(ST_CHUNK_BAD);
         end
         P_CDLF: begin
            if (b == CH_LF) begin
               o_role = ROLE_DELIM; ph = P_CSIZE; acc = 0; vmatch = 0; cr_seen = 0;
            end else fail_with(ST_CHUNK_BAD);
         end
         P_CLLF: begin
            if (b == CH_LF) begin
               o_role = ROLE_DELIM; ph = P_DONE;
            end else fail_with(ST_CHUNK_BAD);
         end
         P_EOS: o_role = ROLE_BODY;
         default: ;
      endcase
      t.role = o_role;
      t.status = (ph == P_DONE || ph == P_EOS) ? ST_COMPLETE : (ph == P_ERR) ? lpos : ST_BUSY;
      t.method_code = (ph != P_MFIRST && ph != P_MLIT && !(ph == P_ERR && lpos == ST_BAD_METHOD))
                      ? meth : METH_NONE;
      t.version_code = ver;
      t.header_index = idx;
      t.field_end = o_fe;
      t.value_length = o_vlen;
      t.body_kind = bmode;
      t.length_value = acc;
      t.byte_offset = offset;
      if (offset != 32'hFFFF_FFFF) offset++;
      return t;
   endfunction

   // Sender and receiver controls.
   int  idle_pct_tx = 8;
   int  idle_pct_rx = 8;
   int  rx_hold = 0;
   tag_t typed_value[$];

   // Receiver: random stalls plus requested long hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= idle_pct_rx);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      tag_t want, got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.role, rsp_chan.status, rsp_chan.method_code, rsp_chan.version_code,
                 rsp_chan.header_index, rsp_chan.field_end, rsp_chan.value_length,
                 rsp_chan.body_kind, rsp_chan.length_value, rsp_chan.byte_offset};
         if (tag_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected transaction: %p", got);
         end else begin
            want = tag_queue.pop_front();
            if (typed_queue.pop_front()) begin
               // Typed rows only pin role and status.
               if (got.role != typed_value[0].role || got.status != typed_value[0].status) begin
                  errors++;
                  if (errors <= 10)
                     $display("Directed mismatch: want role %0d status %0d, got %p",
                              typed_value[0].role, typed_value[0].status, got);
               end
               void'(typed_value.pop_front());
            end
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("Mismatch: want %p got %p", want, got);
            end
         end
      end
   end

   // Watchdog over cycles with no transaction on either side.
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("FAIL http_request_stream_parser_unit");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b, logic restart, logic typed, logic [3:0] r,
                            logic [2:0] s);
      tag_t t;
      while ($urandom_range(99) < idle_pct_tx) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.byte_in <= b;
      req_chan.new_request <= restart;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      t = parse_byte(b, restart);
      tag_queue.push_back(t);
      typed_queue.push_back(typed);
      if (typed) typed_value.push_back('{r, s, 4'd0, 2'd0, 7'd0, 1'b0, 16'd0, 2'd0, 32'd0, 32'd0});
   endtask

   task automatic send_text(string s, logic restart_first);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], restart_first && i == 0, 0, 0, 0);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (tag_queue.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limit(logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      lim = v;
   endtask

   function automatic string rand_token(int n, logic [7:0] lo, logic [7:0] hi);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(hi, lo)))};
      return s;
   endfunction

   function automatic string rand_request(int hmax);
      string mnames[9];
      string s, v;
      int nh, kind, blen;
      mnames = '{"GET", "POST", "PUT", "PATCH", "HEAD", "DELETE", "CONNECT", "OPTIONS", "TRACE"};
      s = {mnames[$urandom_range(8)], " /", rand_token($urandom_range(6), "a", "z"),
           ($urandom_range(1) ? " HTTP/1.1\r\n" : " HTTP/1.0\r\n")};
      nh = $urandom_range(hmax);
      kind = $urandom_range(2);
      blen = $urandom_range(1, 6);
      for (int i = 0; i < nh; i++) begin
         case ($urandom_range(4))
            0: s = {s, "Content-Length:", ($urandom_range(1) ? " " : "\t "),
                    $sformatf("%0d", kind == 1 ? blen : $urandom_range(99)),
                    ($urandom_range(1) ? " " : ""), "\r\n"};
            1: s = {s, "transfer-ENCODING: ", ($urandom_range(1) ? "chunked" : "Chunked \t"),
                    "\r\n"};
            default: begin
               v = rand_token($urandom_range(5), " ", "~");
               s = {s, "X-", rand_token($urandom_range(1, 4), "A", "Z"), ": ", v, "\r\n"};
            end
         endcase
      end
      s = {s, "\r\n"};
      for (int i = 0; i < $urandom_range(2); i++)
         s = {s, $sformatf("%0x", $urandom_range(1, 20)), ";x\r\n", rand_token(8, "a", "z")};
      s = {s, rand_token(blen, "0", "z")};
      return s;
   endfunction

   initial begin
      row_t rows[$];
      string req;
      int n;
      logic [7:0] b;
      req_chan.valid = 1'b0;
      req_chan.byte_in = 8'd0;
      req_chan.new_request = 1'b0;
      lim = HEADER_LIMIT_RESET;
      clear_parse();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bad first byte, lone P method, version errors, chunked body.
      rows = '{
         '{"X", 1, 1, ROLE_IGNORED, ST_BAD_METHOD},
         '{"P", 1, 1, ROLE_METHOD, ST_BUSY},
         '{"X", 0, 1, ROLE_IGNORED, ST_BAD_METHOD},
         '{"G", 1, 1, ROLE_METHOD, ST_BUSY},
         '{"E", 0, 1, ROLE_METHOD, ST_BUSY},
         '{"T", 0, 1, ROLE_METHOD, ST_BUSY},
         '{" ", 0, 1, ROLE_DELIM, ST_BUSY},
         '{" ", 0, 1, ROLE_DELIM, ST_BUSY},
         '{"H", 0, 1, ROLE_VERSION, ST_BUSY},
         '{"X", 0, 1, ROLE_IGNORED, ST_VER_BAD},
         '{8'hFF, 0, 1, ROLE_IGNORED, ST_VER_BAD},
         '{8'h00, 1, 1, ROLE_IGNORED, ST_BAD_METHOD}
      };
      foreach (rows[i]) send_byte(rows[i].data, rows[i].restart, rows[i].typed, rows[i].role,
                                  rows[i].status);
      send_text("PUT / HTTP/1.2\r\n", 1);
      send_text("PATCH /a HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n3\r\nabc\r\n0\r\n\r\n", 1);
      send_text("DELETE / HTTP/1.0\r\nContent-Length: 99999999999\r\nA:\r\n\r\nz", 1);
      send_text("OPTIONS * HTTP/1.1\r\nA\rB:  x\ry \r\n\r\nbody", 1);
      send_text("CONNECT h HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nzz\r\n", 1);
      send_text("TRACE / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nabX", 1);
      send_text("HEAD / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nFFFFFFFFF\r\n", 1);

      // Header limit extremes.
      write_limit(7'd0);
      send_text("GET / HTTP/1.1\r\nA: b\r\n", 1);
      write_limit(7'd1);
      send_text("GET / HTTP/1.1\r\nA: b\r\nC: d\r\n", 1);
      write_limit(7'd127);

      // Long receiver stall while the sender keeps offering bytes.
      rx_hold = 300;
      send_text(rand_request(4), 1);
      send_text(rand_request(4), 1);
      drain();

      n = 0;
      while (n < 1250) begin
         if (n > 500 && n < 800) begin
            idle_pct_tx = 0; idle_pct_rx = 0;
         end else begin
            idle_pct_tx = 8; idle_pct_rx = 8;
         end
         if (n > 900 && n < 1000 && lim != 7'd3) write_limit(7'd3);
         if (n > 1100 && lim != 7'd64) write_limit(7'd64);
         if ($urandom_range(9) == 0) begin
            // Noise and broken requests.
            for (int i = 0; i < 8; i++) begin
               b = $urandom_range(255);
               send_byte(b, i == 0 ? $urandom_range(1) : 1'b0, 0, 0, 0);
            end
            n += 8;
         end else begin
            req = rand_request(5);
            if ($urandom_range(7) == 0) req[$urandom_range(req.len() - 1)] = $urandom_range(255);
            send_text(req, 1);
            n += req.len();
         end
      end
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("PASS http_request_stream_parser_unit");
      else $display("FAIL http_request_stream_parser_unit");
      $finish;
   end
endmodule
`default_nettype wire
